@@ rtl/pmul_pkg.sv @@
// ----------------------------------------------------------------------------
// pmul_pkg
// Shared constants and types for the schoolbook polynomial multiplier.
// ----------------------------------------------------------------------------
package pmul_pkg;

  // Capacity of each coefficient store
  localparam int MAX_TERMS = 32;
  localparam int TERM_AW   = $clog2(MAX_TERMS);
  localparam int CNT_W     = TERM_AW + 1;

  // Product accumulator store
  localparam int ACC_DEPTH = 2 * MAX_TERMS - 1;
  localparam int DEG_W     = $clog2(ACC_DEPTH);

  // Datapath widths
  localparam int COEFF_W = 16;
  localparam int PROD_W  = 2 * COEFF_W;
  localparam int ACC_W   = PROD_W + TERM_AW;

  // Input item modes
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  // Tag that travels with one coefficient pair through the MAC pipeline
  typedef struct packed {
    logic             vld;
    logic             first;  // first pair of this degree
    logic             last;   // last pair of this degree
    logic             fin;    // last pair of the whole product
    logic [DEG_W-1:0] deg;
  } pmul_tag_t;

  // Write port into the accumulator store
  typedef struct packed {
    logic             en;
    logic [DEG_W-1:0] addr;
    logic [ACC_W-1:0] data;
  } pmul_acc_wr_t;

endpackage

@@ rtl/pmul_ram.sv @@
// ----------------------------------------------------------------------------
// pmul_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pmul_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pmul_seq.sv @@
// ----------------------------------------------------------------------------
// pmul_seq
// Pair sequencer: walks output degrees in order and, for each, the valid
// coefficient pairs, issuing one pair of store reads per cycle.
// ----------------------------------------------------------------------------
module pmul_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pmul_pkg::CNT_W-1:0]    na,
  input  logic [pmul_pkg::CNT_W-1:0]    nb,
  output logic [pmul_pkg::TERM_AW-1:0]  a_addr,
  output logic [pmul_pkg::TERM_AW-1:0]  b_addr,
  output pmul_pkg::pmul_tag_t           tag
);

  logic                         active_r, active_nxt;
  logic                         first_r, first_nxt;
  logic [pmul_pkg::DEG_W-1:0]   k_r, k_nxt;
  logic [pmul_pkg::TERM_AW-1:0] i_r, i_nxt;

  logic [pmul_pkg::CNT_W-1:0]   i_hi;
  logic [pmul_pkg::DEG_W:0]     last_k;
  logic [pmul_pkg::DEG_W:0]     k_plus2;
  logic [pmul_pkg::DEG_W:0]     lo_next;
  logic [pmul_pkg::DEG_W-1:0]   j_full;
  logic                         at_hi;
  logic                         fin;

  // Bounds of the pair walk for the current degree
  always_comb begin
    i_hi    = (k_r < na) ? k_r : (na - pmul_pkg::CNT_W'(1));
    last_k  = {1'b0, na} + {1'b0, nb} - (pmul_pkg::DEG_W+1)'(2);
    k_plus2 = {1'b0, k_r} + (pmul_pkg::DEG_W+1)'(2);
    lo_next = (k_plus2 > {1'b0, nb}) ? (k_plus2 - {1'b0, nb}) : '0;
    at_hi   = ({1'b0, i_r} == i_hi);
    fin     = at_hi && ({1'b0, k_r} == last_k);
    j_full  = k_r - {1'b0, i_r};
  end

  // Advance through pairs
  always_comb begin
    active_nxt = active_r;
    first_nxt  = first_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    if (start) begin
      active_nxt = 1'b1;
      first_nxt  = 1'b1;
      k_nxt      = '0;
      i_nxt      = '0;
    end else if (active_r) begin
      if (at_hi) begin
        first_nxt = 1'b1;
        if (fin) begin
          active_nxt = 1'b0;
        end else begin
          k_nxt = k_r + pmul_pkg::DEG_W'(1);
          i_nxt = lo_next[pmul_pkg::TERM_AW-1:0];
        end
      end else begin
        first_nxt = 1'b0;
        i_nxt     = i_r + pmul_pkg::TERM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      first_r  <= 1'b0;
      k_r      <= '0;
      i_r      <= '0;
    end else begin
      active_r <= active_nxt;
      first_r  <= first_nxt;
      k_r      <= k_nxt;
      i_r      <= i_nxt;
    end
  end

  assign a_addr    = i_r;
  assign b_addr    = j_full[pmul_pkg::TERM_AW-1:0];
  assign tag.vld   = active_r;
  assign tag.first = first_r;
  assign tag.last  = at_hi;
  assign tag.fin   = fin;
  assign tag.deg   = k_r;

endmodule

@@ rtl/pmul_mac.sv @@
// ----------------------------------------------------------------------------
// pmul_mac
// Multiply-accumulate pipeline: multiplies the pair read from the stores,
// sums one degree in a register and writes the total to the accumulator
// store. Tracks the highest nonzero degree.
// ----------------------------------------------------------------------------
module pmul_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clear,
  input  pmul_pkg::pmul_tag_t               tag,
  input  logic [pmul_pkg::COEFF_W-1:0]      a_data,
  input  logic [pmul_pkg::COEFF_W-1:0]      b_data,
  output pmul_pkg::pmul_acc_wr_t            acc_wr,
  output logic [pmul_pkg::DEG_W-1:0]        used,
  output logic                              done
);

  pmul_pkg::pmul_tag_t                 s1_r, s2_r;
  logic signed [pmul_pkg::PROD_W-1:0]  prod_r;
  logic signed [pmul_pkg::ACC_W-1:0]   acc_r;
  logic signed [pmul_pkg::ACC_W-1:0]   acc_sum;
  logic signed [pmul_pkg::ACC_W-1:0]   prod_ext;
  logic [pmul_pkg::DEG_W-1:0]          used_r;
  logic                                done_r;

  // Align tag with store read data, then with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= tag;
      s2_r <= s1_r;
    end
  end

  // Multiply
  always_ff @(posedge clk) begin
    prod_r <= $signed(a_data) * $signed(b_data);
  end

  // Accumulate; restart the sum on the first pair of each degree
  always_comb begin
    prod_ext = pmul_pkg::ACC_W'(prod_r);
    acc_sum  = s2_r.first ? prod_ext : (acc_r + prod_ext);
  end

  always_ff @(posedge clk) begin
    if (s2_r.vld) begin
      acc_r <= acc_sum;
    end
  end

  assign acc_wr.en   = s2_r.vld && s2_r.last;
  assign acc_wr.addr = s2_r.deg;
  assign acc_wr.data = acc_sum;

  // Track trimmed length and end of product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= s2_r.vld && s2_r.fin;
      if (clear) begin
        used_r <= '0;
      end else if (acc_wr.en && (acc_sum != '0)) begin
        used_r <= s2_r.deg + pmul_pkg::DEG_W'(1);
      end
    end
  end

  assign used = used_r;
  assign done = done_r;

endmodule

@@ rtl/polynomial_multiply_top.sv @@
// ----------------------------------------------------------------------------
// polynomial_multiply_top
// Schoolbook product of two signed polynomials held in coefficient stores.
//
//   Channel  Dir  Payload                                                     Handshake
//   in_      in   mode, coeff_in                                              valid/ready
//   out_     out  coeff_out, degree, last_coeff, empty_product, overflow_seen valid/ready
//
// A start item runs the MAC walk (one coefficient pair per cycle, set by the
// single read port of each store), drains the pipeline, then emits the results
// in degree order; each is read from the accumulator store through its
// registered read port (ST_ERD) before it is loaded into the output (ST_ELD).
// Reset clears counts, flags and the control state; stores need no clearing.
// A stalled result holds the emit walk; loads are taken while the final result waits.
// ----------------------------------------------------------------------------
module polynomial_multiply_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic signed [pmul_pkg::COEFF_W-1:0] in_coeff_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pmul_pkg::ACC_W-1:0]   out_coeff_out,
  output logic [pmul_pkg::DEG_W-1:0]          out_degree,
  output logic                                out_last_coeff,
  output logic                                out_empty_product,
  output logic                                out_overflow_seen
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_ERD  = 3'd2;
  localparam logic [2:0] ST_ELD  = 3'd3;
  localparam logic [2:0] ST_EMP  = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [pmul_pkg::CNT_W-1:0]      na_r, na_nxt;
  logic [pmul_pkg::CNT_W-1:0]      nb_r, nb_nxt;
  logic                            drop_r, drop_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [pmul_pkg::DEG_W-1:0]      e_r, e_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [pmul_pkg::ACC_W-1:0]      out_coeff_r, out_coeff_nxt;
  logic [pmul_pkg::DEG_W-1:0]      out_deg_r, out_deg_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_empty_r, out_empty_nxt;
  logic                            out_ovf_r, out_ovf_nxt;

  logic                            in_acc;
  logic                            out_free;
  logic                            is_last;
  logic                            start_mac;
  logic                            a_we, b_we;
  logic [pmul_pkg::TERM_AW-1:0]    a_raddr, b_raddr;
  logic [pmul_pkg::COEFF_W-1:0]    a_rdata, b_rdata;
  logic [pmul_pkg::ACC_W-1:0]      acc_rdata;
  logic [pmul_pkg::DEG_W-1:0]      used;
  logic                            mac_done;
  pmul_pkg::pmul_tag_t             tag;
  pmul_pkg::pmul_acc_wr_t          acc_wr;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_last  = (e_r == (used - pmul_pkg::DEG_W'(1)));
  assign a_we     = in_acc && (in_mode == pmul_pkg::MODE_LOAD_A) &&
                    (na_r < pmul_pkg::CNT_W'(pmul_pkg::MAX_TERMS));
  assign b_we     = in_acc && (in_mode == pmul_pkg::MODE_LOAD_B) &&
                    (nb_r < pmul_pkg::CNT_W'(pmul_pkg::MAX_TERMS));

  // Coefficient stores
  pmul_ram #(
    .WIDTH(pmul_pkg::COEFF_W),
    .DEPTH(pmul_pkg::MAX_TERMS)
  ) u_a_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(na_r[pmul_pkg::TERM_AW-1:0]),
    .wdata(in_coeff_in),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  pmul_ram #(
    .WIDTH(pmul_pkg::COEFF_W),
    .DEPTH(pmul_pkg::MAX_TERMS)
  ) u_b_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(nb_r[pmul_pkg::TERM_AW-1:0]),
    .wdata(in_coeff_in),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  // Pair walk and MAC pipeline
  pmul_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_mac),
    .na    (na_r),
    .nb    (nb_r),
    .a_addr(a_raddr),
    .b_addr(b_raddr),
    .tag   (tag)
  );

  pmul_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (start_mac),
    .tag   (tag),
    .a_data(a_rdata),
    .b_data(b_rdata),
    .acc_wr(acc_wr),
    .used  (used),
    .done  (mac_done)
  );

  // Product accumulator store
  pmul_ram #(
    .WIDTH(pmul_pkg::ACC_W),
    .DEPTH(pmul_pkg::ACC_DEPTH)
  ) u_acc_ram (
    .clk  (clk),
    .we   (acc_wr.en),
    .waddr(acc_wr.addr),
    .wdata(acc_wr.data),
    .raddr(e_r),
    .rdata(acc_rdata)
  );

  // Control: loads, start, emit walk
  always_comb begin
    state_nxt     = state_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    drop_nxt      = drop_r;
    ovf_nxt       = ovf_r;
    e_nxt         = e_r;
    start_mac     = 1'b0;
    in_ready      = (state_r == ST_IDLE);

    out_valid_nxt = out_valid_r && !out_ready;
    out_coeff_nxt = out_coeff_r;
    out_deg_nxt   = out_deg_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            pmul_pkg::MODE_LOAD_A: begin
              if (a_we) na_nxt = na_r + pmul_pkg::CNT_W'(1);
              else drop_nxt = 1'b1;
            end
            pmul_pkg::MODE_LOAD_B: begin
              if (b_we) nb_nxt = nb_r + pmul_pkg::CNT_W'(1);
              else drop_nxt = 1'b1;
            end
            pmul_pkg::MODE_START: begin
              ovf_nxt  = drop_r;
              drop_nxt = 1'b0;
              if ((na_r == '0) || (nb_r == '0)) begin
                state_nxt = ST_EMP;
              end else begin
                start_mac = 1'b1;
                state_nxt = ST_MAC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          e_nxt     = '0;
          state_nxt = (used == '0) ? ST_EMP : ST_ERD;
        end
      end
      ST_ERD: begin
        // Read issues on e_r; wait until the output slot frees
        if (out_free) state_nxt = ST_ELD;
      end
      ST_ELD: begin
        out_valid_nxt = 1'b1;
        out_coeff_nxt = acc_rdata;
        out_deg_nxt   = e_r;
        out_last_nxt  = is_last;
        out_empty_nxt = 1'b0;
        out_ovf_nxt   = ovf_r;
        if (is_last) begin
          na_nxt    = '0;
          nb_nxt    = '0;
          state_nxt = ST_IDLE;
        end else begin
          e_nxt     = e_r + pmul_pkg::DEG_W'(1);
          state_nxt = ST_ERD;
        end
      end
      ST_EMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_coeff_nxt = '0;
          out_deg_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          na_nxt        = '0;
          nb_nxt        = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      na_r        <= '0;
      nb_r        <= '0;
      drop_r      <= 1'b0;
      ovf_r       <= 1'b0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
      drop_r      <= drop_nxt;
      ovf_r       <= ovf_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_coeff_r <= out_coeff_nxt;
    out_deg_r   <= out_deg_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_coeff_out     = out_coeff_r;
  assign out_degree        = out_deg_r;
  assign out_last_coeff    = out_last_r;
  assign out_empty_product = out_empty_r;
  assign out_overflow_seen = out_ovf_r;

`ifndef SYNTH
  // Counts never pass the store capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (na_r <= pmul_pkg::CNT_W'(pmul_pkg::MAX_TERMS)) &&
    (nb_r <= pmul_pkg::CNT_W'(pmul_pkg::MAX_TERMS)))
    else $error("coefficient count above capacity");

  // Accumulator store is written only while a product is being formed
  a_acc_wr_mac: assert property (@(posedge clk) disable iff (!rst_n)
    acc_wr.en |-> (state_r == ST_MAC))
    else $error("accumulator write outside MAC phase");

  // Emit walk stays below the trimmed length
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ERD) || (state_r == ST_ELD)) |-> (e_r < used))
    else $error("emit index past trimmed length");

  // Final result of a product clears both counts
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ELD) && is_last) |=> ((na_r == '0) && (nb_r == '0)))
    else $error("counts not cleared after product");
`endif

endmodule

@@ tb/tb_polynomial_multiply_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_multiply_top
// Self-checking bench for the schoolbook polynomial multiplier. Loads and
// start items are driven with bursty valid; every accepted item updates a
// product predictor, and each product coefficient that comes out is checked
// in order against the predicted list, while the result side stalls on a
// changing pattern.
// ----------------------------------------------------------------------------
module tb_polynomial_multiply_top;

  localparam logic [1:0] MODE_IGNORED   = 2'd3;
  localparam int         RANDOM_ITEMS   = 500;
  localparam int         QUIET_LIMIT    = 12000;
  localparam int         DRAIN_CYCLES   = 40;

  // Coefficient sources for the stimulus
  localparam int SRC_RANDOM  = 0;
  localparam int SRC_EXTREME = 1;
  localparam int SRC_SMALL   = 2;
  localparam int SRC_SPARSE  = 3;
  localparam int SRC_MOST_NEG = 4;
  localparam int SRC_MOST_POS = 5;

  typedef struct {
    logic signed [pmul_pkg::ACC_W-1:0] coeff;
    logic [pmul_pkg::DEG_W-1:0]        degree;
    logic                              last;
    logic                              empty;
    logic                              dropped;
  } product_coeff_t;

  // Predicts the product coefficients and checks them as they arrive
  class product_coeff_board;
    logic signed [pmul_pkg::COEFF_W-1:0] first_terms [pmul_pkg::MAX_TERMS];
    logic signed [pmul_pkg::COEFF_W-1:0] second_terms [pmul_pkg::MAX_TERMS];
    int                                  first_count;
    int                                  second_count;
    logic                                dropped;
    product_coeff_t                      pending_coeffs [$];
    int                                  fail_count;

    function new();
      first_count  = 0;
      second_count = 0;
      dropped      = 1'b0;
      fail_count   = 0;
    endfunction

    // Build the whole product and queue its coefficients
    function void form_product();
      longint         acc [pmul_pkg::ACC_DEPTH];
      int             used;
      product_coeff_t pc;
      foreach (acc[k]) acc[k] = 0;
      for (int i = 0; i < first_count; i++)
        for (int j = 0; j < second_count; j++)
          acc[i + j] += longint'(first_terms[i]) * longint'(second_terms[j]);
      used = 0;
      for (int i = 0; i < pmul_pkg::ACC_DEPTH; i++)
        if (acc[i] != 0) used = i + 1;
      if (used == 0) begin
        pc.coeff   = '0;
        pc.degree  = '0;
        pc.last    = 1'b1;
        pc.empty   = 1'b1;
        pc.dropped = dropped;
        pending_coeffs.push_back(pc);
      end else begin
        for (int i = 0; i < used; i++) begin
          pc.coeff   = acc[i][pmul_pkg::ACC_W-1:0];
          pc.degree  = pmul_pkg::DEG_W'(i);
          pc.last    = (i + 1 == used);
          pc.empty   = 1'b0;
          pc.dropped = dropped;
          pending_coeffs.push_back(pc);
        end
      end
      first_count  = 0;
      second_count = 0;
      dropped      = 1'b0;
    endfunction

    // Note one accepted input item
    function void take_item(logic [1:0] mode, logic signed [pmul_pkg::COEFF_W-1:0] value);
      case (mode)
        pmul_pkg::MODE_LOAD_A: begin
          if (first_count < pmul_pkg::MAX_TERMS) begin
            first_terms[first_count] = value;
            first_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        pmul_pkg::MODE_LOAD_B: begin
          if (second_count < pmul_pkg::MAX_TERMS) begin
            second_terms[second_count] = value;
            second_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        pmul_pkg::MODE_START: form_product();
        default: ;  // unused mode, nothing changes
      endcase
    endfunction

    // Compare one accepted result with the oldest predicted coefficient
    function void check_coeff(logic signed [pmul_pkg::ACC_W-1:0] coeff,
                              logic [pmul_pkg::DEG_W-1:0] degree,
                              logic last, logic empty, logic ovf);
      product_coeff_t exp_pc;
      if (pending_coeffs.size() == 0) begin
        $error("unexpected result: coeff_out %0d degree %0d", coeff, degree);
        fail_count++;
        return;
      end
      exp_pc = pending_coeffs.pop_front();
      if (coeff !== exp_pc.coeff) begin
        $error("coeff_out: expected %0d, got %0d", exp_pc.coeff, coeff);
        fail_count++;
      end
      if (degree !== exp_pc.degree) begin
        $error("degree: expected %0d, got %0d", exp_pc.degree, degree);
        fail_count++;
      end
      if (last !== exp_pc.last) begin
        $error("last_coeff: expected %0b, got %0b", exp_pc.last, last);
        fail_count++;
      end
      if (empty !== exp_pc.empty) begin
        $error("empty_product: expected %0b, got %0b", exp_pc.empty, empty);
        fail_count++;
      end
      if (ovf !== exp_pc.dropped) begin
        $error("overflow_seen: expected %0b, got %0b", exp_pc.dropped, ovf);
        fail_count++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [1:0]                          in_mode = pmul_pkg::MODE_LOAD_A;
  logic signed [pmul_pkg::COEFF_W-1:0] in_coeff_in = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [pmul_pkg::ACC_W-1:0]   out_coeff_out;
  logic [pmul_pkg::DEG_W-1:0]          out_degree;
  logic                                out_last_coeff;
  logic                                out_empty_product;
  logic                                out_overflow_seen;

  product_coeff_board board = new();
  int                 burst_left = 0;
  int                 items_sent = 0;
  int                 quiet_cycles = 0;
  int                 stall_style = 0;
  int                 stall_left = 0;
  int                 stall_phase = 0;

  polynomial_multiply_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_coeff_in      (in_coeff_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coeff_out    (out_coeff_out),
    .out_degree       (out_degree),
    .out_last_coeff   (out_last_coeff),
    .out_empty_product(out_empty_product),
    .out_overflow_seen(out_overflow_seen)
  );

  always #2 clk = ~clk;

  // Receiver: switch between always ready, random stalls and a fixed stall rhythm
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(20, 200);
      stall_phase = 0;
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % 7;
    case (stall_style)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      default: out_ready = (stall_phase >= 3);
    endcase
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_coeff(out_coeff_out, out_degree, out_last_coeff, out_empty_product,
                        out_overflow_seen);
  end

  // Watchdog: end the run after a long stretch with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Drive one item, with a random gap at the start of each burst; hold until accepted
  task automatic send_item(input logic [1:0] mode,
                           input logic signed [pmul_pkg::COEFF_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid    = 1'b1;
    in_mode     = mode;
    in_coeff_in = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_item(mode, value);
    if (mode != MODE_IGNORED) items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic signed [pmul_pkg::COEFF_W-1:0] pick_coeff(int src);
    logic signed [pmul_pkg::COEFF_W-1:0] v;
    case (src)
      SRC_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = -16'sd1;
          3: v = 16'sd1;
          default: v = '0;
        endcase
      end
      SRC_SMALL:    v = pmul_pkg::COEFF_W'($urandom_range(0, 16)) - 16'sd8;
      SRC_SPARSE:   v = ($urandom_range(0, 9) < 7) ? '0 : pmul_pkg::COEFF_W'($urandom);
      SRC_MOST_NEG: v = 16'sh8000;
      SRC_MOST_POS: v = 16'sh7fff;
      default:      v = pmul_pkg::COEFF_W'($urandom);
    endcase
    return v;
  endfunction

  // Load both polynomials in random interleaved order, with some noise, then start
  task automatic load_and_start(input int na, input int nb, input int src_a, input int src_b);
    int la;
    int lb;
    la = 0;
    lb = 0;
    while (la < na || lb < nb) begin
      if ($urandom_range(0, 19) == 0) send_item(MODE_IGNORED, pmul_pkg::COEFF_W'($urandom));
      if (lb >= nb || (la < na && $urandom_range(0, 1) == 1)) begin
        send_item(pmul_pkg::MODE_LOAD_A, pick_coeff(src_a));
        la++;
      end else begin
        send_item(pmul_pkg::MODE_LOAD_B, pick_coeff(src_b));
        lb++;
      end
    end
    send_item(pmul_pkg::MODE_START, pmul_pkg::COEFF_W'($urandom));
  endtask

  initial begin
    int base;
    int r;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty operands, extremes, zero product, trimming, inner zero
    send_item(pmul_pkg::MODE_START, 16'sh7fff);
    send_item(pmul_pkg::MODE_LOAD_A, 16'sh8000);
    send_item(pmul_pkg::MODE_LOAD_B, 16'sh8000);
    send_item(pmul_pkg::MODE_START, '0);
    send_item(pmul_pkg::MODE_LOAD_A, 16'sh7fff);
    send_item(pmul_pkg::MODE_LOAD_A, 16'sh8000);
    send_item(pmul_pkg::MODE_LOAD_B, 16'sh7fff);
    send_item(pmul_pkg::MODE_LOAD_B, -16'sd1);
    send_item(pmul_pkg::MODE_START, 16'sh8000);
    send_item(pmul_pkg::MODE_LOAD_A, '0);
    send_item(pmul_pkg::MODE_LOAD_A, '0);
    send_item(pmul_pkg::MODE_LOAD_B, 16'sd7);
    send_item(pmul_pkg::MODE_START, '0);
    send_item(pmul_pkg::MODE_LOAD_A, 16'sd5);
    send_item(pmul_pkg::MODE_START, '0);
    send_item(MODE_IGNORED, 16'sh5a5a);
    send_item(pmul_pkg::MODE_LOAD_A, 16'sd1);
    send_item(pmul_pkg::MODE_LOAD_A, '0);
    send_item(pmul_pkg::MODE_LOAD_A, '0);
    send_item(pmul_pkg::MODE_LOAD_B, -16'sd3);
    send_item(MODE_IGNORED, -16'sh5a5b);
    send_item(pmul_pkg::MODE_START, '0);
    send_item(pmul_pkg::MODE_LOAD_B, 16'sd1);
    send_item(pmul_pkg::MODE_LOAD_B, 16'sd1);
    send_item(pmul_pkg::MODE_LOAD_A, 16'sd1);
    send_item(pmul_pkg::MODE_LOAD_A, -16'sd1);
    send_item(pmul_pkg::MODE_START, '0);

    // Full stores at the extremes, with dropped loads past capacity
    base = items_sent;
    load_and_start(34, 33, SRC_MOST_NEG, SRC_MOST_NEG);
    load_and_start(32, 35, SRC_MOST_NEG, SRC_MOST_POS);

    // Random sequences, mostly small, some full or overfull, some one-sided
    while (items_sent - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        load_and_start($urandom_range(0, 6), $urandom_range(0, 6),
                       $urandom_range(SRC_RANDOM, SRC_SPARSE),
                       $urandom_range(SRC_RANDOM, SRC_SPARSE));
      end else if (r < 75) begin
        load_and_start($urandom_range(1, 16), $urandom_range(1, 16),
                       $urandom_range(SRC_RANDOM, SRC_SPARSE),
                       $urandom_range(SRC_RANDOM, SRC_SPARSE));
      end else if (r < 80) begin
        load_and_start($urandom_range(30, 34), $urandom_range(30, 34),
                       $urandom_range(SRC_RANDOM, SRC_MOST_POS),
                       $urandom_range(SRC_RANDOM, SRC_MOST_POS));
      end else if (r < 90) begin
        load_and_start($urandom_range(33, 37), $urandom_range(0, 4),
                       $urandom_range(SRC_RANDOM, SRC_SPARSE), SRC_RANDOM);
      end else if (r < 95) begin
        load_and_start(0, $urandom_range(0, 5), SRC_RANDOM, SRC_RANDOM);
      end else begin
        load_and_start($urandom_range(1, 5), 0, SRC_EXTREME, SRC_RANDOM);
      end
    end

    // Drain: wait for every predicted coefficient, then watch for strays
    in_valid = 1'b0;
    while (board.pending_coeffs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ polynomial_multiply_top.f @@
rtl/pmul_pkg.sv
rtl/pmul_ram.sv
rtl/pmul_seq.sv
rtl/pmul_mac.sv
rtl/polynomial_multiply_top.sv
tb/tb_polynomial_multiply_top.sv
